### rtl/cst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, token codes and character classes of the tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] LEN_MAX   = 16'hFFFF;
    localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

    localparam logic [3:0] KIND_EOF        = 4'd0;
    localparam logic [3:0] KIND_INT        = 4'd1;
    localparam logic [3:0] KIND_RETURN     = 4'd2;
    localparam logic [3:0] KIND_IDENT      = 4'd3;
    localparam logic [3:0] KIND_LITERAL    = 4'd4;
    localparam logic [3:0] KIND_LPAREN     = 4'd5;
    localparam logic [3:0] KIND_RPAREN     = 4'd6;
    localparam logic [3:0] KIND_LBRACE     = 4'd7;
    localparam logic [3:0] KIND_RBRACE     = 4'd8;
    localparam logic [3:0] KIND_SEMI       = 4'd9;
    localparam logic [3:0] KIND_PLUS       = 4'd10;
    localparam logic [3:0] KIND_MINUS      = 4'd11;
    localparam logic [3:0] KIND_TILDE      = 4'd12;
    localparam logic [3:0] KIND_BANG       = 4'd13;
    localparam logic [3:0] KIND_BAD_LIT    = 4'd14;
    localparam logic [3:0] KIND_UNEXPECTED = 4'd15;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_WORD = 4'b0010,
        MODE_NUM  = 4'b0100,
        MODE_ERR  = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [30:0] value;
        logic        overflow;
        logic        last;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_scan_result;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        return is_space(c) || (c == 8'h28) || (c == 8'h29) || (c == 8'h7B)
            || (c == 8'h7D) || (c == 8'h3B) || (c == 8'h00);
    endfunction

    // Returns KIND_EOF when the character is not a single-character token.
    function automatic logic [3:0] single_kind(input logic [7:0] c);
        logic [3:0] k;
        unique case (c)
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h3B:   k = KIND_SEMI;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h7E:   k = KIND_TILDE;
            8'h21:   k = KIND_BANG;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

    function automatic logic kw_int_hit(input logic [15:0] idx, input logic [7:0] c);
        logic hit;
        unique case (idx)
            16'd0:   hit = (c == 8'h69);
            16'd1:   hit = (c == 8'h6E);
            16'd2:   hit = (c == 8'h74);
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic kw_ret_hit(input logic [15:0] idx, input logic [7:0] c);
        logic hit;
        unique case (idx)
            16'd0:   hit = (c == 8'h72);
            16'd1:   hit = (c == 8'h65);
            16'd2:   hit = (c == 8'h74);
            16'd3:   hit = (c == 8'h75);
            16'd4:   hit = (c == 8'h72);
            16'd5:   hit = (c == 8'h6E);
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Bit 0 tracks the keyword int and bit 1 the keyword return.
    function automatic logic [1:0] alive_next(input logic [1:0] alive,
                                              input logic [15:0] idx,
                                              input logic [7:0] c);
        return {alive[1] & kw_ret_hit(idx, c), alive[0] & kw_int_hit(idx, c)};
    endfunction

endpackage
`default_nettype wire

### rtl/cst_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_if
// Valid/ready channels for source characters and for tokens.
// ----------------------------------------------------------------------------
interface cst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_source;

    modport source (output valid, output ch, output end_of_source, input ready);
    modport sink (input valid, input ch, input end_of_source, output ready);
endinterface

interface cst_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [30:0] literal_value;
    logic        literal_overflow;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output literal_value,
                    output literal_overflow, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_length, input literal_value,
                  input literal_overflow, input last_of_run, output ready);
endinterface
`default_nettype wire

### rtl/cst_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_scan
// Scanner state and the per-character decision; yields up to two tokens.
// ----------------------------------------------------------------------------
module cst_scan #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_fire,
    input  wire logic [7:0]            i_ch,
    input  wire logic                  i_eos,
    output cst_pkg::t_scan_result      o_res
);
    import cst_pkg::*;

    t_mode                    r_mode,  n_mode;
    logic [POSITION_BITS-1:0] r_pos,   n_pos;
    logic [15:0]              r_start, n_start;
    logic [15:0]              r_len,   n_len;
    logic [30:0]              r_acc,   n_acc;
    logic                     r_sat,   n_sat;
    logic [1:0]               r_alive, n_alive;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [15:0]              here;
    logic [15:0]              len_inc;
    logic [34:0]              mac;
    t_token                   pend_tok;
    t_token                   idle_tok;
    logic                     idle_has;
    t_mode                    idle_mode;
    t_token                   sec_tok;
    logic                     sec_has;
    logic                     prefix;
    logic                     use_idle;

    assign pos_inc = r_pos + POSITION_BITS'(1);
    assign here    = 16'(r_pos);
    assign len_inc = (r_len == LEN_MAX) ? r_len : r_len + 16'd1;
    assign mac     = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + 35'(i_ch[3:0]);

    always_comb begin
        pend_tok          = '0;
        pend_tok.start    = r_start;
        pend_tok.length   = r_len;
        if (r_mode == MODE_NUM) begin
            pend_tok.kind     = KIND_LITERAL;
            pend_tok.value    = r_acc;
            pend_tok.overflow = r_sat;
        end else if (r_alive[0] && (r_len == 16'd3)) begin
            pend_tok.kind = KIND_INT;
        end else if (r_alive[1] && (r_len == 16'd6)) begin
            pend_tok.kind = KIND_RETURN;
        end else begin
            pend_tok.kind = KIND_IDENT;
        end
    end

    always_comb begin
        idle_tok        = '0;
        idle_tok.start  = here;
        idle_tok.length = 16'd1;
        idle_has        = 1'b0;
        idle_mode       = MODE_IDLE;
        if (is_space(i_ch)) begin
            idle_mode = MODE_IDLE;
        end else if (is_alpha(i_ch)) begin
            idle_mode = MODE_WORD;
        end else if (is_digit(i_ch)) begin
            idle_mode = MODE_NUM;
        end else if (single_kind(i_ch) != KIND_EOF) begin
            idle_has      = 1'b1;
            idle_tok.kind = single_kind(i_ch);
        end else begin
            idle_has      = 1'b1;
            idle_tok.kind = KIND_UNEXPECTED;
            idle_mode     = MODE_ERR;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_start  = r_start;
        n_len    = r_len;
        n_acc    = r_acc;
        n_sat    = r_sat;
        n_alive  = r_alive;
        prefix   = 1'b0;
        use_idle = 1'b0;
        sec_tok  = '0;
        sec_has  = 1'b0;
        if (i_fire) begin
            if (i_eos) begin
                prefix        = (r_mode == MODE_WORD) || (r_mode == MODE_NUM);
                sec_has       = 1'b1;
                sec_tok.kind  = KIND_EOF;
                sec_tok.start = here;
                n_mode        = MODE_IDLE;
                n_pos         = '0;
                n_start       = '0;
                n_len         = '0;
                n_acc         = '0;
                n_sat         = 1'b0;
                n_alive       = 2'b11;
            end else begin
                unique case (r_mode)
                    MODE_ERR: begin
                        n_pos = pos_inc;
                    end
                    MODE_WORD: begin
                        if (is_term(i_ch)) begin
                            prefix   = 1'b1;
                            use_idle = 1'b1;
                        end else begin
                            n_alive = alive_next(r_alive, r_len, i_ch);
                            n_len   = len_inc;
                            n_pos   = pos_inc;
                        end
                    end
                    MODE_NUM: begin
                        if (is_term(i_ch)) begin
                            prefix   = 1'b1;
                            use_idle = 1'b1;
                        end else if (is_digit(i_ch)) begin
                            if (mac > 35'(VALUE_MAX)) begin
                                n_acc = VALUE_MAX;
                                n_sat = 1'b1;
                            end else begin
                                n_acc = mac[30:0];
                            end
                            n_len = len_inc;
                            n_pos = pos_inc;
                        end else begin
                            sec_has        = 1'b1;
                            sec_tok.kind   = KIND_BAD_LIT;
                            sec_tok.start  = r_start;
                            sec_tok.length = len_inc;
                            n_mode         = MODE_ERR;
                            n_pos          = pos_inc;
                        end
                    end
                    MODE_IDLE: begin
                        use_idle = 1'b1;
                    end
                    default: begin
                        n_mode = MODE_IDLE;
                    end
                endcase
                if (use_idle) begin
                    sec_has = idle_has;
                    sec_tok = idle_tok;
                    n_mode  = idle_mode;
                    n_pos   = pos_inc;
                    if ((idle_mode == MODE_WORD) || (idle_mode == MODE_NUM)) begin
                        n_start = here;
                        n_len   = 16'd1;
                    end
                    if (idle_mode == MODE_WORD) begin
                        n_alive = alive_next(2'b11, 16'd0, i_ch);
                    end
                    if (idle_mode == MODE_NUM) begin
                        n_acc = 31'(i_ch[3:0]);
                        n_sat = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        o_res = '0;
        if (prefix) begin
            o_res.tok0      = pend_tok;
            o_res.tok0.last = !sec_has;
            o_res.tok1      = sec_tok;
            o_res.tok1.last = 1'b1;
            o_res.count     = sec_has ? 2'd2 : 2'd1;
        end else if (sec_has) begin
            o_res.tok0      = sec_tok;
            o_res.tok0.last = 1'b1;
            o_res.count     = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_acc   <= '0;
            r_sat   <= 1'b0;
            r_alive <= 2'b11;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_sat   <= n_sat;
            r_alive <= n_alive;
        end
    end

endmodule
`default_nettype wire

### rtl/cst_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_out_queue
// Small token queue that takes up to two tokens a cycle and sends one whenever the sink is ready.
// ----------------------------------------------------------------------------
module cst_out_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire cst_pkg::t_scan_result i_res,
    output logic                       o_ready,
    cst_out_if.source                  o_out
);
    import cst_pkg::*;

    t_token              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, n_wr;
    logic [QUEUE_AW-1:0] r_rd, n_rd;
    logic [QUEUE_CW-1:0] r_cnt, n_cnt;
    logic                pop;
    t_token              head;

    assign head    = r_mem[r_rd];
    assign pop     = o_out.valid && o_out.ready;
    assign o_ready = r_cnt <= QUEUE_CW'(QUEUE_DEPTH - 2);

    assign o_out.valid            = r_cnt != '0;
    assign o_out.token_kind       = head.kind;
    assign o_out.token_start      = head.start;
    assign o_out.token_length     = head.length;
    assign o_out.literal_value    = head.value;
    assign o_out.literal_overflow = head.overflow;
    assign o_out.last_of_run      = head.last;

    always_comb begin
        n_wr  = r_wr + QUEUE_AW'(i_res.count);
        n_rd  = pop ? r_rd + QUEUE_AW'(1) : r_rd;
        n_cnt = r_cnt + QUEUE_CW'(i_res.count) - QUEUE_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_res.count != 2'd0) begin
            r_mem[r_wr] <= i_res.tok0;
        end
        if (i_res.count == 2'd2) begin
            r_mem[r_wr + QUEUE_AW'(1)] <= i_res.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

### rtl/c_subset_tokenizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c_subset_tokenizer_unit
// Streaming tokenizer for a small C subset, one source character per request.
// ----------------------------------------------------------------------------
// The output is valid in the cycle after a request that yields a token.
// One character per cycle while the input is ready; a character that yields two
// tokens sends them out one after the other from the four-entry token queue.
// The input is ready while the queue has room for two tokens.
// Reset: synchronous, active low; clears scanner state and the queue.
module c_subset_tokenizer_unit #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cst_in_if.sink    i_in,
    cst_out_if.source o_out
);
    import cst_pkg::*;

    logic         in_fire;
    logic         q_ready;
    t_scan_result scan_res;

    assign i_in.ready = q_ready;
    assign in_fire    = i_in.valid && q_ready;

    cst_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_ch    (i_in.ch),
        .i_eos   (i_in.end_of_source),
        .o_res   (scan_res)
    );

    cst_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (scan_res),
        .o_ready (q_ready),
        .o_out   (o_out)
    );

    a_token_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (scan_res.count != 2'd0) |=> o_out.valid)
        else $error("token not offered after its request");

    a_eos_gives_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.end_of_source |->
            ((scan_res.count == 2'd1) && (scan_res.tok0.kind == KIND_EOF))
            || ((scan_res.count == 2'd2) && (scan_res.tok1.kind == KIND_EOF)))
        else $error("end of source did not close with an eof token");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with an empty token queue");

endmodule
`default_nettype wire
